>>> hw/rtl/rstab_pkg.sv
package rstab_pkg;

  // Default table depth and cap on resends emitted by one tick
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned MaxResults   = 16;

  // Timeout register value after reset
  localparam logic [15:0] TimeoutReset = 16'd5;

  // Command codes
  localparam logic [2:0] CmdPush      = 3'd0;
  localparam logic [2:0] CmdFindSeq   = 3'd1;
  localparam logic [2:0] CmdFindFlags = 3'd2;
  localparam logic [2:0] CmdFindAny   = 3'd3;
  localparam logic [2:0] CmdPop       = 3'd4;
  localparam logic [2:0] CmdTick      = 3'd5;

  // Command transaction payload
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] seq_num;
    logic [7:0]  flag_bits;
    logic [15:0] payload_tag;
  } cmd_t;

  // Result transaction payload
  typedef struct packed {
    logic        hit;
    logic [15:0] out_seq;
    logic [7:0]  out_flags;
    logic [15:0] out_tag;
    logic        resend;
    logic        last;
  } res_t;

  // One slot as held in the table memory
  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  flags;
    logic [15:0] tag;
    logic [31:0] stamp;
  } slot_t;

endpackage

>>> hw/rtl/rstab_stream_if.sv
// Valid/ready channel carrying one payload per transaction
interface rstab_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rstab_match.sv
// Shared slot evaluator: equality compares and the 32-bit age compare
module rstab_match (
  input  logic [2:0]          command_i,
  input  logic [15:0]         seq_i,
  input  logic [7:0]          flags_i,
  input  rstab_pkg::slot_t    slot_i,
  input  logic                slot_valid_i,
  input  logic [31:0]         now_i,
  input  logic [15:0]         timeout_i,
  output logic                take_o
);
  import rstab_pkg::*;

  logic [31:0] age;
  logic        due;

  // Age wraps modulo 2^32
  assign age = now_i - slot_i.stamp;
  assign due = age > {16'd0, timeout_i};

  // Does this slot satisfy the current command
  always_comb begin
    case (command_i)
      CmdPush:      take_o = ~slot_valid_i;
      CmdFindSeq:   take_o = slot_valid_i && (slot_i.seq == seq_i);
      CmdFindFlags: take_o = slot_valid_i && (slot_i.flags == flags_i);
      CmdFindAny:   take_o = slot_valid_i;
      CmdPop:       take_o = slot_valid_i && (slot_i.seq == seq_i);
      CmdTick:      take_o = slot_valid_i && due;
      default:      take_o = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/retransmit_slot_table_core.sv
// Retransmit slot table: SLOTS outstanding-packet slots, each holding a sequence
// number, flags, payload tag and send stamp, scanned from index 0 upward one
// slot at a time (memory read, then compare in the shared match unit).
// The command port is ready only when the sequencer is idle. Push, find and pop
// stop at the first selected slot, or after the last slot on a miss. A tick
// walks all slots unless it stops early at the slot that gives its sixteenth
// resend. Every command also waits while the result port is stalled. A tick
// emits one result per due slot (at most 16, lowest indices first) and restamps
// each, or a single zero result if none is due; the last result of every
// command carries last. All slots are empty after reset; no clearing pass is
// needed. timeout_q resets to 5 and is written through cfg_i.
module retransmit_slot_table_core #(
  parameter int unsigned SLOTS = rstab_pkg::SlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rstab_stream_if.sink  cmd_i,
  rstab_stream_if.source res_o,
  rstab_stream_if.sink  cfg_i
);
  import rstab_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StCheck = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] n_q, n_d;
  cmd_t            req_q, req_d;
  logic [31:0]     now_q, now_d;
  logic [15:0]     timeout_q;
  logic [SLOTS-1:0] valid_q, valid_d;
  res_t            pend_q, pend_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_data_q, res_data_d;

  slot_t           mem [SLOTS];
  slot_t           rd_q;
  logic            mem_we;
  slot_t           mem_wdata;
  logic            take;
  logic            out_free;

  assign cmd_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;
  assign out_free    = ~res_valid_q | res_o.ready;

  // Slot memory: one write and one registered read per cycle at the scan index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= mem_wdata;
    end
    rd_q <= mem[idx_q];
  end

  // Shared compare unit
  rstab_match u_match (
    .command_i    (req_q.command),
    .seq_i        (req_q.seq_num),
    .flags_i      (req_q.flag_bits),
    .slot_i       (rd_q),
    .slot_valid_i (valid_q[idx_q]),
    .now_i        (now_q),
    .timeout_i    (timeout_q),
    .take_o       (take)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    req_d       = req_q;
    now_d       = now_q;
    valid_d     = valid_q;
    pend_d      = pend_q;
    res_valid_d = res_valid_q & ~res_o.ready;
    res_data_d  = res_data_q;
    mem_we      = 1'b0;
    mem_wdata   = rd_q;

    case (state_q)
      StIdle: begin
        if (cmd_i.valid) begin
          req_d  = cmd_i.data;
          idx_d  = '0;
          n_d    = '0;
          pend_d = '0;
          // time advances before the tick scan
          if (cmd_i.data.command == CmdTick) begin
            now_d = now_q + 32'd1;
          end
          state_d = StRead;
        end
      end

      StRead: begin
        state_d = StCheck;
      end

      StCheck: begin
        if (take) begin
          case (req_q.command)
            CmdPush: begin
              mem_we          = 1'b1;
              mem_wdata.seq   = req_q.seq_num;
              mem_wdata.flags = req_q.flag_bits;
              mem_wdata.tag   = req_q.payload_tag;
              mem_wdata.stamp = now_q;
              valid_d[idx_q]  = 1'b1;
              pend_d.hit      = 1'b1;
              state_d         = StFlush;
            end
            CmdFindSeq, CmdFindFlags, CmdFindAny: begin
              pend_d.hit       = 1'b1;
              pend_d.out_seq   = rd_q.seq;
              pend_d.out_flags = rd_q.flags;
              pend_d.out_tag   = rd_q.tag;
              state_d          = StFlush;
            end
            CmdPop: begin
              valid_d[idx_q] = 1'b0;
              pend_d.hit     = 1'b1;
              state_d        = StFlush;
            end
            CmdTick: begin
              // a held resend goes out first, not marked last
              if (!pend_q.hit || out_free) begin
                if (pend_q.hit) begin
                  res_valid_d = 1'b1;
                  res_data_d  = pend_q;
                end
                mem_we           = 1'b1;
                mem_wdata.stamp  = now_q;
                pend_d.hit       = 1'b1;
                pend_d.out_seq   = rd_q.seq;
                pend_d.out_flags = rd_q.flags;
                pend_d.out_tag   = rd_q.tag;
                pend_d.resend    = 1'b1;
                pend_d.last      = 1'b0;
                n_d              = n_q + 1'b1;
                if (n_q == CntW'(MaxResults - 1) || idx_q == IdxW'(SLOTS - 1)) begin
                  state_d = StFlush;
                end else begin
                  idx_d   = idx_q + 1'b1;
                  state_d = StRead;
                end
              end
            end
            default: begin
              state_d = StFlush;
            end
          endcase
        end else if (idx_q == IdxW'(SLOTS - 1)) begin
          state_d = StFlush;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StRead;
        end
      end

      StFlush: begin
        // final result of the command; zero result on a miss
        if (out_free) begin
          res_valid_d     = 1'b1;
          res_data_d      = pend_q;
          res_data_d.last = 1'b1;
          state_d         = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      now_q       <= '0;
      timeout_q   <= TimeoutReset;
      res_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      now_q       <= now_d;
      res_valid_q <= res_valid_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      if (cfg_i.valid && cfg_i.ready) begin
        timeout_q <= cfg_i.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pend_q     <= pend_d;
    res_data_q <= res_data_d;
  end

`ifndef SYNTHESIS
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && cmd_i.data.command == CmdTick)
      |=> (now_q == $past(now_q) + 32'd1))
    else $error("tick did not advance time by one");

  a_push_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck && take && req_q.command == CmdPush)
      |=> valid_q[$past(idx_q)])
    else $error("pushed slot not marked valid");

  a_resend_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxResults))
    else $error("resend count above cap");

  a_write_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StCheck))
    else $error("slot write outside compare step");
`endif

endmodule

>>> tb/sv/tb_retransmit_slot_table_core.sv
`timescale 1ns / 1ps

module tb_retransmit_slot_table_core;
  import rstab_pkg::*;

  localparam int unsigned Slots = SlotsDefault;
  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 10;
  // One full table walk, taken twice as settling time after the last result
  localparam int ScanCycles    = 2 * Slots + 2;
  localparam int SettleCycles  = 2 * ScanCycles;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 4000;
  localparam int MaxPrinted    = 40;
  localparam int PhaseItems    = 73;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CmdSpareLo = 3'd6;
  localparam logic [2:0] CmdSpareHi = 3'd7;

  typedef enum int {RxAlways, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  // Shadow copy of the slot table; builds the expected results of each command
  class slot_table_scoreboard;
    logic [15:0] timeout;
    logic        valid_q [Slots];
    logic [15:0] seq_q   [Slots];
    logic [7:0]  flags_q [Slots];
    logic [15:0] tag_q   [Slots];
    logic [31:0] stamp_q [Slots];
    logic [31:0] now;
    res_t        expected_results[$];
    int          errors;

    function new();
      timeout = TimeoutReset;
      now     = '0;
      errors  = 0;
      for (int i = 0; i < Slots; i++) begin
        valid_q[i] = 1'b0;
        seq_q[i]   = '0;
        flags_q[i] = '0;
        tag_q[i]   = '0;
        stamp_q[i] = '0;
      end
    endfunction

    function void set_timeout(logic [15:0] value);
      timeout = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted command and queue the results it must cause
    function void note_command(cmd_t c);
      res_t        r;
      res_t        burst [MaxResults];
      int          n;
      int          idx;
      logic [31:0] age;
      r      = '0;
      r.last = 1'b1;
      idx    = -1;
      n      = 0;
      case (c.command)
        CmdPush: begin
          for (int i = 0; i < Slots; i++) begin
            if (idx < 0 && !valid_q[i]) idx = i;
          end
          if (idx >= 0) begin
            valid_q[idx] = 1'b1;
            seq_q[idx]   = c.seq_num;
            flags_q[idx] = c.flag_bits;
            tag_q[idx]   = c.payload_tag;
            stamp_q[idx] = now;
            r.hit        = 1'b1;
          end
          expected_results.push_back(r);
        end
        CmdFindSeq, CmdFindFlags, CmdFindAny: begin
          for (int i = 0; i < Slots; i++) begin
            if (idx < 0 && valid_q[i] &&
                (c.command == CmdFindAny ||
                 (c.command == CmdFindSeq && seq_q[i] == c.seq_num) ||
                 (c.command == CmdFindFlags && flags_q[i] == c.flag_bits))) idx = i;
          end
          if (idx >= 0) begin
            r.hit       = 1'b1;
            r.out_seq   = seq_q[idx];
            r.out_flags = flags_q[idx];
            r.out_tag   = tag_q[idx];
          end
          expected_results.push_back(r);
        end
        CmdPop: begin
          for (int i = 0; i < Slots; i++) begin
            if (idx < 0 && valid_q[i] && seq_q[i] == c.seq_num) idx = i;
          end
          if (idx >= 0) begin
            valid_q[idx] = 1'b0;
            r.hit        = 1'b1;
          end
          expected_results.push_back(r);
        end
        CmdTick: begin
          // time moves first, then due slots go out lowest index first
          now = now + 32'd1;
          for (int i = 0; i < Slots; i++) begin
            age = now - stamp_q[i];
            if (n < MaxResults && valid_q[i] && age > {16'd0, timeout}) begin
              burst[n]           = '0;
              burst[n].hit       = 1'b1;
              burst[n].out_seq   = seq_q[i];
              burst[n].out_flags = flags_q[i];
              burst[n].out_tag   = tag_q[i];
              burst[n].resend    = 1'b1;
              stamp_q[i]         = now;
              n++;
            end
          end
          if (n == 0) begin
            expected_results.push_back(r);
          end else begin
            burst[n-1].last = 1'b1;
            for (int k = 0; k < n; k++) expected_results.push_back(burst[k]);
          end
        end
        default: begin
          expected_results.push_back(r);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] result error: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: seq %h last %b",
                                  got.out_seq, got.last));
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
      if (got.out_seq !== want.out_seq)
        report_mismatch($sformatf("out_seq %h, expected %h", got.out_seq, want.out_seq));
      if (got.out_flags !== want.out_flags)
        report_mismatch($sformatf("out_flags %h, expected %h", got.out_flags, want.out_flags));
      if (got.out_tag !== want.out_tag)
        report_mismatch($sformatf("out_tag %h, expected %h", got.out_tag, want.out_tag));
      if (got.resend !== want.resend)
        report_mismatch($sformatf("resend %b, expected %b", got.resend, want.resend));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  rstab_stream_if #(.payload_t(cmd_t))        cmd_if ();
  rstab_stream_if #(.payload_t(res_t))        res_if ();
  rstab_stream_if #(.payload_t(logic [15:0])) cfg_if ();

  slot_table_scoreboard sb;
  int burst_left    = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  retransmit_slot_table_core #(
    .SLOTS (Slots)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.data);
  end

  // Watchdog: ends the run after a long stretch without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result sink: ready pattern changes now and then; long hold-off on request
  initial begin : result_sink
    rx_mode_e mode;
    int       mode_left;
    int       cyc;
    mode         = RxAlways;
    mode_left    = 0;
    cyc          = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (holds_done < hold_requests) begin
        holds_done++;
        res_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          RxAlways: res_if.ready <= 1'b1;
          RxCoin:   res_if.ready <= 1'($urandom_range(0, 1));
          RxSparse: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:  res_if.ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] op, logic [15:0] seq, logic [7:0] flags,
                                    logic [15:0] tag);
    cmd_t c;
    c.command     = op;
    c.seq_num     = seq;
    c.flag_bits   = flags;
    c.payload_tag = tag;
    return c;
  endfunction

  // Random command; small seq/flag pools make finds and pops hit often
  function automatic cmd_t random_command(int push_pct, int pop_pct, int tick_pct);
    cmd_t c;
    int   r;
    r             = $urandom_range(0, 99);
    c.seq_num     = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    c.flag_bits   = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    c.payload_tag = 16'($urandom);
    if (r < push_pct) c.command = CmdPush;
    else if (r < push_pct + 10) c.command = CmdFindSeq;
    else if (r < push_pct + 18) c.command = CmdFindFlags;
    else if (r < push_pct + 22) c.command = CmdFindAny;
    else if (r < push_pct + 22 + pop_pct) c.command = CmdPop;
    else if (r < push_pct + 22 + pop_pct + tick_pct) c.command = CmdTick;
    else c.command = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
    return c;
  endfunction

  // Offer one command in bursts with random gaps; note it once accepted
  task automatic send_command(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_timeout(value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering, wait for every expected result, then let the block settle
  task automatic drain();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic run_phase(input logic [15:0] tmo, input int push_pct, input int pop_pct,
                           input int tick_pct, input bit long_hold);
    write_timeout(tmo);
    if (long_hold) hold_requests++;
    repeat (PhaseItems) send_command(random_command(push_pct, pop_pct, tick_pct));
    drain();
  endtask

  initial begin : stimulus
    sb           = new();
    rst_n        = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, field extremes, misses, stale slot, spare codes, resends
    send_command(make_cmd(CmdTick, 16'h0000, 8'h00, 16'h0000));
    send_command(make_cmd(CmdFindAny, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_command(make_cmd(CmdPop, 16'h0000, 8'h00, 16'h0000));
    send_command(make_cmd(CmdPush, 16'h0000, 8'h00, 16'h0000));
    send_command(make_cmd(CmdPush, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_command(make_cmd(CmdPush, 16'h1234, 8'hA5, 16'h5A5A));
    send_command(make_cmd(CmdFindSeq, 16'hFFFF, 8'h00, 16'h0000));
    send_command(make_cmd(CmdFindSeq, 16'h0000, 8'hFF, 16'hFFFF));
    send_command(make_cmd(CmdFindSeq, 16'h7777, 8'h00, 16'h0000));
    send_command(make_cmd(CmdFindFlags, 16'h0000, 8'hFF, 16'h0000));
    send_command(make_cmd(CmdFindFlags, 16'h0000, 8'h3C, 16'h0000));
    send_command(make_cmd(CmdFindAny, 16'h0000, 8'h00, 16'h0000));
    send_command(make_cmd(CmdPop, 16'h0000, 8'hFF, 16'hFFFF));
    // freed slot still holds its old contents but must not match
    send_command(make_cmd(CmdFindFlags, 16'h0000, 8'h00, 16'h0000));
    send_command(make_cmd(CmdFindSeq, 16'h0000, 8'h00, 16'h0000));
    send_command(make_cmd(CmdPush, 16'h4321, 8'h00, 16'hFFFF));
    send_command(make_cmd(CmdSpareLo, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_command(make_cmd(CmdSpareHi, 16'h0000, 8'h00, 16'h0000));
    repeat (7) send_command(make_cmd(CmdTick, 16'hFFFF, 8'hFF, 16'hFFFF));
    drain();

    // Random phases over several timeout settings
    run_phase(16'd0, 45, 8, 22, 1'b1);
    run_phase(16'hFFFF, 30, 20, 25, 1'b0);
    run_phase(16'd1, 25, 20, 30, 1'b0);
    run_phase(16'($urandom_range(2, 12)), 30, 15, 30, 1'b1);
    run_phase(16'($urandom), 30, 25, 20, 1'b0);
    run_phase(TimeoutReset, 35, 15, 25, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
